// ===== src/fit_block_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// fit_block_allocator_assert.svh
// assertion macros for the fit block allocator
// ----------------------------------------------------------------------------
`ifndef FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define FBA_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FBA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`else

`define FBA_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define FBA_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

// ===== src/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// shared constants, codes and types of the fit block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fba_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 32;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = $clog2(NUM_BLOCKS);

    // fixed field widths of the ports
    localparam int OPC_W   = 2;
    localparam int BIDX_W  = 5;
    localparam int VAL_W   = 16;
    localparam int LIMIT_W = 6;
    localparam int MODE_W  = 2;

    // widths for compares and block addressing
    localparam int CMP_W  = (IDX_BITS + 1 > LIMIT_W) ? IDX_BITS + 1 : LIMIT_W;
    localparam int ADDR_W = (IDX_BITS > BIDX_W) ? IDX_BITS : BIDX_W;

    // opcodes
    localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPC_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

    // fit modes, anything else acts as first fit
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    // register indexes
    localparam logic CFG_FIT_MODE      = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // search token handed from cell to cell
    typedef struct packed {
        logic                 active;
        logic [SIZE_BITS-1:0] request;
        logic                 have;
        logic [IDX_BITS-1:0]  pick;
        logic [SIZE_BITS-1:0] left;
    } tok_t;

    // broadcast control to all cells
    typedef struct packed {
        logic                 load;
        logic                 clear;
        logic                 grant;
        logic [ADDR_W-1:0]    addr;
        logic [SIZE_BITS-1:0] size;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// fit_block_allocator
// first, best or worst fit allocator over a chain of block cells
// ----------------------------------------------------------------------------
// load and clear beats act when accepted; the next beat can follow right after
// an allocate beat walks the cell chain one cell per cycle; SCAN captures the token at
// the chain end, DONE registers the result when the output is free and returns to IDLE;
// the result sits in an output register, so the next beat is taken while it waits
// reset: all blocks free, fit_mode first fit, blocks_in_use 32, sizes undefined
`timescale 1ns / 1ps
`default_nettype none

`include "fit_block_allocator_assert.svh"

module fit_block_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input beats
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // block_index[4:0], size_value[20:5], zero fill
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    // result beats
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // granted_block[4:0], fragment[20:5], zero fill
    output logic             m_tuser,   // found[0]
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [5:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [fba_pkg::MODE_W-1:0]      fit_mode_reg;
    logic [fba_pkg::LIMIT_W-1:0]     blocks_reg;
    fba_pkg::tok_t                   end_reg;
    fba_pkg::tok_t                   links [fba_pkg::NUM_BLOCKS+1];
    fba_pkg::cell_ctl_t              ctl;
    logic                            in_acc;
    logic                            out_free;
    logic                            m_tvalid_reg;
    logic                            found_reg;
    logic [fba_pkg::BIDX_W-1:0]      grant_reg;
    logic [fba_pkg::VAL_W-1:0]       frag_reg;
    logic [fba_pkg::OPC_W-1:0]       opcode;
    logic [fba_pkg::BIDX_W-1:0]      block_index;
    logic [fba_pkg::VAL_W-1:0]       size_value;

    assign opcode      = s_tuser;
    assign block_index = s_tdata[4:0];
    assign size_value  = s_tdata[20:5];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= fba_pkg::MODE_FIRST;
            blocks_reg   <= fba_pkg::LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fba_pkg::CFG_FIT_MODE:      fit_mode_reg <= cfg_wdata[1:0];
                fba_pkg::CFG_BLOCKS_IN_USE: blocks_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // token injected into the first cell
    always_comb begin
        links[0].active  = in_acc && (opcode == fba_pkg::OP_ALLOC);
        links[0].request = fba_pkg::SIZE_BITS'(size_value);
        links[0].have    = 1'b0;
        links[0].pick    = '0;
        links[0].left    = '0;
    end

    // broadcast control: load, clear and the grant of a finished search
    always_comb begin
        ctl.load  = in_acc && (opcode == fba_pkg::OP_LOAD);
        ctl.clear = in_acc && (opcode == fba_pkg::OP_CLEAR);
        ctl.grant = (state_reg == ST_DONE) && out_free && end_reg.have;
        ctl.size  = fba_pkg::SIZE_BITS'(size_value);
        if (state_reg == ST_DONE) begin
            ctl.addr = fba_pkg::ADDR_W'(end_reg.pick);
        end else begin
            ctl.addr = fba_pkg::ADDR_W'(block_index);
        end
    end

    // cell chain
    for (genvar g = 0; g < fba_pkg::NUM_BLOCKS; g++) begin : g_cell
        fba_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cell_idx      (fba_pkg::IDX_BITS'(g)),
            .fit_mode      (fit_mode_reg),
            .blocks_in_use (blocks_reg),
            .ctl           (ctl),
            .tok_in        (links[g]),
            .tok_out       (links[g+1])
        );
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (links[0].active)                       state_next = ST_SCAN;
            ST_SCAN: if (links[fba_pkg::NUM_BLOCKS].active)     state_next = ST_DONE;
            ST_DONE: if (out_free)                              state_next = ST_IDLE;
            default:                                            state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the token leaving the last cell
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN && links[fba_pkg::NUM_BLOCKS].active) begin
            end_reg <= links[fba_pkg::NUM_BLOCKS];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            found_reg <= end_reg.have;
            if (end_reg.have) begin
                grant_reg <= fba_pkg::BIDX_W'(end_reg.pick);
                frag_reg  <= fba_pkg::VAL_W'(end_reg.left);
            end else begin
                grant_reg <= '0;
                frag_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {3'b000, frag_reg, grant_reg};

    // checks
    `FBA_ASSERT_NEXT(a_alloc_starts_scan, aclk, aresetn, links[0].active, state_reg == ST_SCAN, "allocate beat did not start a scan")
    `FBA_ASSERT_IMPL(a_token_only_in_scan, aclk, aresetn, links[fba_pkg::NUM_BLOCKS].active, state_reg == ST_SCAN, "token left the chain outside a scan")
    `FBA_ASSERT_NEXT(a_done_gives_beat, aclk, aresetn, state_reg == ST_DONE && out_free, m_tvalid && state_reg == ST_IDLE, "finished search produced no result beat")
    `FBA_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready, "input taken during a search")

endmodule

`default_nettype wire

// ===== src/fba_cell.sv =====
// ----------------------------------------------------------------------------
// fba_cell
// one table block: size, taken mark and one stage of the search chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fba_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [fba_pkg::IDX_BITS-1:0]  cell_idx,
    input  wire logic [fba_pkg::MODE_W-1:0]    fit_mode,
    input  wire logic [fba_pkg::LIMIT_W-1:0]   blocks_in_use,
    input  wire fba_pkg::cell_ctl_t            ctl,
    input  wire fba_pkg::tok_t                 tok_in,
    output fba_pkg::tok_t                      tok_out
);

    logic [fba_pkg::SIZE_BITS-1:0] size_reg;
    logic                          taken_reg;
    fba_pkg::tok_t                 tok_reg;
    fba_pkg::tok_t                 tok_next;
    logic                          hit;
    logic                          fits;
    logic [fba_pkg::SIZE_BITS-1:0] rest;

    assign hit  = (fba_pkg::ADDR_W'(cell_idx) == ctl.addr);
    assign rest = size_reg - tok_in.request;

    // block takes part, is free and is large enough
    assign fits = tok_in.active && !taken_reg && (size_reg >= tok_in.request)
               && (fba_pkg::CMP_W'(cell_idx) < fba_pkg::CMP_W'(blocks_in_use));

    // update the running choice
    always_comb begin
        tok_next = tok_in;
        if (fits) begin
            if (!tok_in.have) begin
                tok_next.have = 1'b1;
                tok_next.pick = cell_idx;
                tok_next.left = rest;
            end else if (fit_mode == fba_pkg::MODE_BEST && rest < tok_in.left) begin
                tok_next.pick = cell_idx;
                tok_next.left = rest;
            end else if (fit_mode == fba_pkg::MODE_WORST && rest > tok_in.left) begin
                tok_next.pick = cell_idx;
                tok_next.left = rest;
            end
        end
    end

    // hand token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // taken mark
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= 1'b0;
        end else if (ctl.clear) begin
            taken_reg <= 1'b0;
        end else if (ctl.load && hit) begin
            taken_reg <= 1'b0;
        end else if (ctl.grant && hit) begin
            taken_reg <= 1'b1;
        end
    end

    // block size, undefined until loaded
    always_ff @(posedge aclk) begin
        if (ctl.load && hit) begin
            size_reg <= ctl.size;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
